FILE: sv/nrl_pkg.sv
// ----------------------------------------------------------------------------
// nrl_pkg: shared types and constants for the nonce replay ledger
// Table geometry, field widths, result codes and the request record that
// travels from the front end through the queue to the scan engine.
// ----------------------------------------------------------------------------
package nrl_pkg;

  localparam int unsigned ENTRIES     = 256;
  localparam int unsigned IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned NOW_W       = 63;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned DIGEST_W    = 4 * WORD_W;
  localparam int unsigned WIN_W       = 32;
  localparam int unsigned CODE_W      = 2;
  localparam int unsigned SLOT_W      = 8;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(600);

  typedef enum logic [CODE_W-1:0] {
    RES_ACCEPTED = 2'd0,
    RES_REPLAY   = 2'd1,
    RES_FULL     = 2'd2
  } nrl_result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_REPORT
  } nrl_state_t;

  // zero_time: request carries a time of zero and is refused without a scan
  typedef struct packed {
    logic                zero_time;
    logic [NOW_W-1:0]    now_time;
    logic [DIGEST_W-1:0] digest;
  } nrl_task_t;

endpackage

FILE: sv/nrl_req_if.sv
// ----------------------------------------------------------------------------
// nrl_req_if: request channel of the nonce replay ledger
// Valid/ready handshake carrying the current time and the four digest words.
// ----------------------------------------------------------------------------
interface nrl_req_if import nrl_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [NOW_W-1:0]   now_time;
  logic [WORD_W-1:0]  digest_w0;
  logic [WORD_W-1:0]  digest_w1;
  logic [WORD_W-1:0]  digest_w2;
  logic [WORD_W-1:0]  digest_w3;

  modport source (
    output valid, now_time, digest_w0, digest_w1, digest_w2, digest_w3,
    input  ready
  );

  modport sink (
    input  valid, now_time, digest_w0, digest_w1, digest_w2, digest_w3,
    output ready
  );

endinterface

FILE: sv/nrl_rsp_if.sv
// ----------------------------------------------------------------------------
// nrl_rsp_if: result channel of the nonce replay ledger
// Valid/ready handshake carrying the result code and the slot written.
// ----------------------------------------------------------------------------
interface nrl_rsp_if import nrl_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [CODE_W-1:0]  result_code;
  logic [SLOT_W-1:0]  slot_index;

  modport source (
    output valid, result_code, slot_index,
    input  ready
  );

  modport sink (
    input  valid, result_code, slot_index,
    output ready
  );

endinterface

FILE: sv/nrl_front.sv
// ----------------------------------------------------------------------------
// nrl_front: request intake
// Takes requests, flags a zero time and holds one request for the queue.
// ----------------------------------------------------------------------------
module nrl_front import nrl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clearing,
  input  logic              req_valid,
  output logic              req_ready,
  input  logic [NOW_W-1:0]  req_now_time,
  input  logic [WORD_W-1:0] req_w0,
  input  logic [WORD_W-1:0] req_w1,
  input  logic [WORD_W-1:0] req_w2,
  input  logic [WORD_W-1:0] req_w3,
  output logic              push_valid,
  input  logic              push_ready,
  output nrl_task_t         push_task
);

  logic      hold_valid_r, hold_valid_nxt;
  nrl_task_t hold_task_r, hold_task_nxt;
  logic      take;

  // no intake while the table is being wiped
  assign req_ready  = ~clearing & (~hold_valid_r | push_ready);
  assign take       = req_valid & req_ready;
  assign push_valid = hold_valid_r;
  assign push_task  = hold_task_r;

  always_comb begin
    hold_valid_nxt = hold_valid_r & ~push_ready;
    hold_task_nxt  = hold_task_r;
    if (take) begin
      hold_valid_nxt          = 1'b1;
      hold_task_nxt.zero_time = (req_now_time == '0);
      hold_task_nxt.now_time  = req_now_time;
      hold_task_nxt.digest    = {req_w0, req_w1, req_w2, req_w3};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_task_r <= hold_task_nxt;
  end

endmodule

FILE: sv/nrl_queue.sv
// ----------------------------------------------------------------------------
// nrl_queue: request queue between intake and scan engine
// Small register FIFO so both sides can stall independently.
// ----------------------------------------------------------------------------
module nrl_queue import nrl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  nrl_task_t push_task,
  output logic      pop_valid,
  input  logic      pop_ready,
  output nrl_task_t pop_task
);

  nrl_task_t           slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_task   = slot_q[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_q[wr_ptr_r] <= push_task;
    end
  end

endmodule

FILE: sv/nrl_scan.sv
// ----------------------------------------------------------------------------
// nrl_scan: table scan engine
// Owns the entry table, wipes it after reset, walks every entry per request
// of nonzero time, writes the free slot on an accept; result is registered.
// ----------------------------------------------------------------------------
module nrl_scan import nrl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [WIN_W-1:0]  window,
  output logic              clearing,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  nrl_task_t         pop_task,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output logic [CODE_W-1:0] rsp_code,
  output logic [SLOT_W-1:0] rsp_slot
);

  typedef struct packed {
    logic [NOW_W-1:0]    stamp;
    logic [DIGEST_W-1:0] digest;
  } nrl_row_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  nrl_row_t            mem [ENTRIES];
  nrl_row_t            rd_row_r;
  logic                rd_vld_r;
  logic [IDX_W-1:0]    rd_idx_r;

  nrl_state_t          state_r, state_nxt;
  logic [IDX_W-1:0]    addr_r, addr_nxt;
  nrl_task_t           task_r, task_nxt;
  logic                found_r, found_nxt;
  logic                have_slot_r, have_slot_nxt;
  logic [IDX_W-1:0]    slot_r, slot_nxt;
  logic                out_valid_r, out_valid_nxt;
  nrl_result_t         code_r, code_nxt;
  logic [SLOT_W-1:0]   oslot_r, oslot_nxt;

  logic                rd_en;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  nrl_row_t            mem_wdata;

  logic [NOW_W-1:0]    age;
  logic                live;
  logic                match;

  assign clearing  = (state_r == ST_CLEAR);
  assign rsp_valid = out_valid_r;
  assign rsp_code  = code_r;
  assign rsp_slot  = oslot_r;

  // liveness: nonzero stamp, and either in the future or within the window
  assign age   = task_r.now_time - rd_row_r.stamp;
  assign live  = (rd_row_r.stamp != '0) &&
                 ((rd_row_r.stamp > task_r.now_time) || (age <= NOW_W'(window)));
  assign match = (rd_row_r.digest == task_r.digest);

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    task_nxt      = task_r;
    found_nxt     = found_r;
    have_slot_nxt = have_slot_r;
    slot_nxt      = slot_r;
    out_valid_nxt = out_valid_r & ~rsp_ready;
    code_nxt      = code_r;
    oslot_nxt     = oslot_r;
    pop_ready     = 1'b0;
    rd_en         = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = addr_r;
    mem_wdata     = '0;

    if (rd_vld_r) begin
      if (live && match) begin
        found_nxt = 1'b1;
      end
      if (!live && !have_slot_r) begin
        have_slot_nxt = 1'b1;
        slot_nxt      = rd_idx_r;
      end
    end

    unique case (state_r)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == LAST_IDX) begin
          addr_nxt  = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          task_nxt      = pop_task;
          found_nxt     = 1'b0;
          have_slot_nxt = 1'b0;
          slot_nxt      = '0;
          addr_nxt      = '0;
          state_nxt     = pop_task.zero_time ? ST_REPORT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        rd_en    = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == LAST_IDX) begin
          addr_nxt  = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // last read is folded this cycle
        state_nxt = ST_REPORT;
      end
      ST_REPORT: begin
        if (!out_valid_r || rsp_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (found_r) begin
            code_nxt  = RES_REPLAY;
            oslot_nxt = '0;
          end else if (have_slot_r) begin
            code_nxt         = RES_ACCEPTED;
            oslot_nxt        = SLOT_W'(slot_r);
            mem_we           = 1'b1;
            mem_waddr        = slot_r;
            mem_wdata.stamp  = task_r.now_time;
            mem_wdata.digest = task_r.digest;
          end else begin
            code_nxt  = RES_FULL;
            oslot_nxt = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r      <= '0;
      found_r     <= 1'b0;
      have_slot_r <= 1'b0;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
    end else begin
      addr_r      <= addr_nxt;
      found_r     <= found_nxt;
      have_slot_r <= have_slot_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    task_r   <= task_nxt;
    slot_r   <= slot_nxt;
    code_r   <= code_nxt;
    oslot_r  <= oslot_nxt;
    rd_idx_r <= addr_r;
  end

  // entry table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_row_r <= mem[addr_r];
    end
  end

endmodule

FILE: sv/nonce_replay_ledger.sv
// ----------------------------------------------------------------------------
// nonce_replay_ledger: replay filter for request digests with a time window
// Each request carries the current time and a 256-bit digest. The ledger keeps
// ENTRIES entries of stamp plus digest; an entry is live when its stamp is
// nonzero and either lies after now or is no more than window_seconds older.
// A live entry with the same digest makes the request a replay (code 1).
// Otherwise the lowest non-live entry takes the time and digest and the
// request is accepted (code 0, slot_index = entry). With every entry live the
// request is refused as table full (code 2); a time of zero is refused the
// same way without touching the table. After reset the table is wiped entry
// by entry while requests are held off; cfg writes still land. In the scan
// engine a request is popped, every table entry is read, one per cycle,
// through the single read port, then it drains and reports; a zero-time
// request is only popped and reported. Intake and a two-deep queue let the
// next requests arrive while one is scanned, and a result register lets the
// next scan run while a result waits to be taken.
// ----------------------------------------------------------------------------
module nonce_replay_ledger import nrl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  nrl_req_if.sink          in_req,
  nrl_rsp_if.source        out_rsp,
  input  logic             cfg_we,
  input  logic [WIN_W-1:0] cfg_wdata
);

  // window register; the user must write it only while the block is idle, the block does not enforce it
  logic [WIN_W-1:0] window_r, window_nxt;

  logic      clearing;
  logic      push_valid, push_ready;
  nrl_task_t push_task;
  logic      pop_valid, pop_ready;
  nrl_task_t pop_task;

  assign window_nxt = cfg_we ? cfg_wdata : window_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RESET;
    end else begin
      window_r <= window_nxt;
    end
  end

  // front: takes requests and tags refused times
  nrl_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .clearing     (clearing),
    .req_valid    (in_req.valid),
    .req_ready    (in_req.ready),
    .req_now_time (in_req.now_time),
    .req_w0       (in_req.digest_w0),
    .req_w1       (in_req.digest_w1),
    .req_w2       (in_req.digest_w2),
    .req_w3       (in_req.digest_w3),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_task    (push_task)
  );

  // decoupling queue
  nrl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_task  (push_task),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_task   (pop_task)
  );

  // back: table wipe, scan, slot write and result register
  nrl_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .window    (window_r),
    .clearing  (clearing),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_task  (pop_task),
    .rsp_valid (out_rsp.valid),
    .rsp_ready (out_rsp.ready),
    .rsp_code  (out_rsp.result_code),
    .rsp_slot  (out_rsp.slot_index)
  );

endmodule

FILE: sim/nonce_replay_ledger_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nonce_replay_ledger_test: self-checking bench for the nonce replay ledger
// Requests are queued by a stimulus process and handed to the request
// channel by a clocked driver that works in bursts with random gaps. The
// result channel is open, rotates a pattern or stalls at random. Every accepted
// request is run through a local copy of the ledger (stamps, digests and
// window) and the verdict is compared against the next result that leaves
// the block. The window register is swept through zero, one, reset, random
// and all-ones values, the table is driven to full, and times cover the
// whole 63-bit range.
// ----------------------------------------------------------------------------
module nonce_replay_ledger_test;
  import nrl_pkg::*;

  localparam int unsigned     RESET_CYCLES = 6;
  // tail wait after the last result, long enough for one more scan
  localparam int unsigned     DRAIN_CYCLES = ENTRIES + 50;
  // the limit lies above the slowest legal run of roughly 1300 requests *
  // (gap + scan + stall), on a clock period of 8 ns
  localparam longint unsigned RUN_LIMIT_NS = 64'd50_000_000;
  localparam int unsigned     POOL_DEPTH   = 32;
  localparam int unsigned     MAX_REPORTS  = 100;

  localparam logic [NOW_W-1:0]    NOW_MAX    = '1;
  localparam logic [WIN_W-1:0]    WINDOW_MAX = '1;
  localparam logic [DIGEST_W-1:0] DIGEST_ONES = '1;

  typedef struct packed {
    logic [NOW_W-1:0]    now_time;
    logic [DIGEST_W-1:0] digest;
  } ledger_req_t;

  // verdict the ledger owes for one request; now_time kept for messages
  typedef struct packed {
    logic [NOW_W-1:0]  now_time;
    nrl_result_t       code;
    logic [SLOT_W-1:0] slot;
  } ledger_verdict_t;

  // receiver behavior, picked anew at random intervals
  typedef enum logic [1:0] {
    RDY_OPEN,
    RDY_PATTERN,
    RDY_STALLS
  } rdy_mode_t;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [WIN_W-1:0] cfg_wdata = '0;

  nrl_req_if req_if ();
  nrl_rsp_if rsp_if ();

  nonce_replay_ledger u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (req_if),
    .out_rsp  (rsp_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Local ledger: the state the block should hold after each request
  // --------------------------------------------------------------------------
  logic [63:0]         ledger_stamp  [ENTRIES];
  logic [DIGEST_W-1:0] ledger_digest [ENTRIES];
  logic [WIN_W-1:0]    ledger_window;

  // Bookkeeping between stimulus, driver and monitor
  ledger_req_t         pending_reqs [$];    // queued, not yet on the wire
  ledger_verdict_t     verdicts_due [$];    // accepted, result not yet seen
  logic [DIGEST_W-1:0] recent_digests [$];  // source of replays and near misses
  logic [NOW_W-1:0]    time_base;           // running clock for random phases

  int unsigned queued_total   = 0;
  int unsigned accepted_total = 0;
  int unsigned mismatch_count = 0;
  int unsigned seen_stored    = 0;
  int unsigned seen_replay    = 0;
  int unsigned seen_full      = 0;
  bit          req_fire       = 1'b0;

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("[%0t] MISMATCH %s", $time, what);
    end
  endtask

  // Scan the table the way the block does: a live entry with the same digest
  // is a replay; else the lowest entry that is not live takes the request.
  // Live means nonzero stamp, and either in the future or within the window.
  function automatic ledger_verdict_t judge_request(ledger_req_t r);
    ledger_verdict_t v;
    logic [63:0]     now64;
    logic            live;
    int              free_slot;
    int              i;
    now64     = {1'b0, r.now_time};
    free_slot = -1;
    v.now_time = r.now_time;
    v.code     = RES_FULL;
    v.slot     = '0;
    // a time of zero is refused as full without looking at the table
    if (r.now_time == '0) return v;
    for (i = 0; i < ENTRIES; i++) begin
      live = (ledger_stamp[i] != 64'd0) &&
             ((ledger_stamp[i] > now64) ||
              (now64 - ledger_stamp[i] <= {32'd0, ledger_window}));
      if (live && ledger_digest[i] == r.digest) begin
        v.code = RES_REPLAY;
        return v;
      end
      if (!live && free_slot < 0) free_slot = i;
    end
    if (free_slot >= 0) begin
      ledger_stamp[free_slot]  = now64;
      ledger_digest[free_slot] = r.digest;
      v.code = RES_ACCEPTED;
      v.slot = SLOT_W'(free_slot);
    end
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Request generation
  // --------------------------------------------------------------------------
  function automatic logic [DIGEST_W-1:0] fresh_digest();
    return {$urandom(), $urandom(), $urandom(), $urandom(),
            $urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  // Mix of fresh digests, exact repeats (mostly the latest, so the age of
  // the match is the last time step), single-bit near misses, all ones and all zeros.
  function automatic logic [DIGEST_W-1:0] pick_digest();
    int unsigned         sel;
    int unsigned         idx;
    logic [DIGEST_W-1:0] d;
    sel = $urandom_range(0, 99);
    d   = fresh_digest();
    if (recent_digests.size() == 0 || sel < 45) return d;
    idx = $urandom_range(0, recent_digests.size() - 1);
    if (sel < 70) return recent_digests[$];
    if (sel < 88) return recent_digests[idx];
    if (sel < 96) return recent_digests[idx] ^ (DIGEST_W'(1) << $urandom_range(0, DIGEST_W - 1));
    return sel[0] ? DIGEST_ONES : '0;
  endfunction

  task automatic queue_request(logic [NOW_W-1:0] now_time, logic [DIGEST_W-1:0] digest);
    pending_reqs.push_back('{now_time: now_time, digest: digest});
    queued_total++;
    recent_digests.push_back(digest);
    if (recent_digests.size() > POOL_DEPTH) void'(recent_digests.pop_front());
  endtask

  // Time mostly creeps forward, sometimes jumps by about the window so that
  // repeats land on either side of the age limit, sometimes steps back so
  // that stored stamps lie in the future, and now and then is zero.
  task automatic add_random_requests(int unsigned count);
    int unsigned      sel;
    logic [63:0]      step;
    logic [63:0]      span;
    logic [NOW_W-1:0] now_time;
    repeat (count) begin
      sel = $urandom_range(0, 99);
      if (sel < 3) begin
        now_time = '0;
      end else if (sel < 88) begin
        if (sel < 55) begin
          step = $urandom_range(0, 3);
        end else if (sel < 75) begin
          // window - 1, window or window + 1
          step = {32'd0, ledger_window} + $urandom_range(0, 2);
          if (step != 64'd0) step = step - 1;
        end else begin
          span = 2 * {32'd0, ledger_window} + 2;
          step = {$urandom(), $urandom()} % span;
        end
        time_base = time_base + NOW_W'(step);
        now_time  = time_base;
      end else begin
        now_time = time_base - $urandom_range(1, 50);
      end
      queue_request(now_time, pick_digest());
    end
  endtask

  // Idle means every queued request was taken and every verdict arrived.
  // Checked at the falling edge, where the monitor's updates have settled.
  task automatic wait_idle();
    do @(negedge clk);
    while (accepted_total != queued_total || verdicts_due.size() != 0);
  endtask

  // Called from the falling edge while idle; lands at the next rising edge.
  task automatic write_window(logic [WIN_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    ledger_window = value;
  endtask

  // --------------------------------------------------------------------------
  // Driver: burst of requests, then a gap; a held request stays on the wire
  // until it is taken. req_fire says the last rising edge took the request.
  // --------------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(negedge clk) begin : driver
    ledger_req_t nxt;
    int unsigned pick;
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else if (req_fire || !req_if.valid) begin
      if (gap_left > 0) begin
        gap_left--;
        req_if.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        nxt = pending_reqs.pop_front();
        req_if.valid     <= 1'b1;
        req_if.now_time  <= nxt.now_time;
        req_if.digest_w0 <= nxt.digest[255:192];
        req_if.digest_w1 <= nxt.digest[191:128];
        req_if.digest_w2 <= nxt.digest[127:64];
        req_if.digest_w3 <= nxt.digest[63:0];
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          // short gaps while a scan runs, long ones to land on other phases
          burst_left = $urandom_range(0, 15);
          pick       = $urandom_range(0, 9);
          gap_left   = (pick < 5) ? 0 : (pick < 9) ? $urandom_range(1, 8)
                                                   : $urandom_range(100, 300);
        end
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: open, a rotating 8-bit ready pattern, or random long stalls
  // --------------------------------------------------------------------------
  rdy_mode_t   rdy_mode       = RDY_OPEN;
  int unsigned rdy_mode_left  = 0;
  int unsigned rdy_stall_left = 0;
  logic [7:0]  rdy_pattern    = 8'hFF;

  always @(negedge clk) begin : receiver
    if (rdy_mode_left == 0) begin
      rdy_mode      = rdy_mode_t'($urandom_range(0, 2));
      rdy_mode_left = $urandom_range(200, 2000);
      rdy_pattern   = 8'($urandom()) | 8'h01;
    end else begin
      rdy_mode_left--;
    end
    case (rdy_mode)
      RDY_OPEN: begin
        rsp_if.ready <= 1'b1;
      end
      RDY_PATTERN: begin
        rsp_if.ready <= rdy_pattern[0];
        rdy_pattern   = {rdy_pattern[0], rdy_pattern[7:1]};
      end
      default: begin
        if (rdy_stall_left > 0) begin
          rsp_if.ready <= 1'b0;
          rdy_stall_left--;
        end else begin
          rsp_if.ready <= 1'b1;
          if ($urandom_range(0, 15) == 0) rdy_stall_left = $urandom_range(1, 200);
        end
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on every taken request, check every delivered result.
  // Both in one block so a verdict is queued before any result is compared.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    ledger_req_t     taken;
    ledger_verdict_t want;
    if (!rst_n) begin
      req_fire <= 1'b0;
    end else begin
      req_fire <= req_if.valid && req_if.ready;
      if (req_if.valid && req_if.ready) begin
        taken.now_time = req_if.now_time;
        taken.digest   = {req_if.digest_w0, req_if.digest_w1,
                          req_if.digest_w2, req_if.digest_w3};
        verdicts_due.push_back(judge_request(taken));
        accepted_total++;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch($sformatf("result code %0d slot %0d with no request outstanding",
                                    rsp_if.result_code, rsp_if.slot_index));
        end else begin
          want = verdicts_due.pop_front();
          if (rsp_if.result_code !== want.code) begin
            report_mismatch($sformatf("now %0d: result_code %0d, expected %0d",
                                      want.now_time, rsp_if.result_code, want.code));
          end
          if (rsp_if.slot_index !== want.slot) begin
            report_mismatch($sformatf("now %0d: slot_index %0d, expected %0d",
                                      want.now_time, rsp_if.slot_index, want.slot));
          end
          case (want.code)
            RES_ACCEPTED: seen_stored++;
            RES_REPLAY:   seen_replay++;
            default:      seen_full++;
          endcase
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [NOW_W-1:0] fill_base;
    logic [NOW_W-1:0] now_time;
    int unsigned      sel;
    int               i;

    req_if.valid     = 1'b0;
    req_if.now_time  = '0;
    req_if.digest_w0 = '0;
    req_if.digest_w1 = '0;
    req_if.digest_w2 = '0;
    req_if.digest_w3 = '0;
    rsp_if.ready     = 1'b0;

    for (i = 0; i < ENTRIES; i++) begin
      ledger_stamp[i]  = '0;
      ledger_digest[i] = '0;
    end
    ledger_window = WINDOW_RESET;
    time_base     = NOW_W'(2000);

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests on the reset window of 600, table empty. They sit
    // in the queue while the block wipes its table after reset.
    queue_request('0, DIGEST_ONES);                        // zero time refused
    queue_request(NOW_W'(1), '0);                          // first store, slot 0
    queue_request(NOW_W'(1), '0);                          // same time: replay
    queue_request(NOW_W'(601), '0);                        // age equals window
    queue_request(NOW_W'(602), '0);                        // one past: reused
    queue_request(NOW_W'(602), DIGEST_W'(1));
    queue_request(NOW_W'(602), DIGEST_W'(1) << (DIGEST_W - 1));
    queue_request(NOW_W'(602), DIGEST_ONES);
    queue_request(NOW_W'(602), DIGEST_ONES ^ DIGEST_W'(1));           // last word
    queue_request(NOW_W'(602), DIGEST_ONES ^ (DIGEST_W'(1) << 192));  // first word
    queue_request(NOW_W'(500), DIGEST_ONES);               // stamps in the future
    queue_request(NOW_W'(500), DIGEST_W'(5));
    queue_request('0, '0);                                 // zero time beats a match
    queue_request(NOW_W'(1202), '0);                       // window edge again
    queue_request(NOW_W'(1203), DIGEST_W'(1));             // everything aged out
    queue_request(NOW_W'(1203), '0);

    // Random phases across the window settings, drained before each write
    wait_idle();
    write_window('0);
    add_random_requests(160);

    wait_idle();
    write_window(WIN_W'(1));
    add_random_requests(160);

    wait_idle();
    write_window($urandom());
    add_random_requests(160);

    wait_idle();
    write_window(WINDOW_RESET);
    add_random_requests(200);

    // Fill the table: widest window, time jumped past every stored stamp,
    // mostly new digests until every entry is live.
    wait_idle();
    write_window(WINDOW_MAX);
    time_base = time_base + NOW_W'(64'h1_0000_0100);
    fill_base = time_base;
    repeat (300) begin
      if ($urandom_range(0, 3) == 0) time_base = time_base + 1;
      queue_request(time_base, ($urandom_range(0, 9) == 0) ? pick_digest() : fresh_digest());
    end
    // every stamp now in the future: new digests full, old ones replays
    repeat (4) queue_request(fill_base - $urandom_range(1, 9), fresh_digest());
    repeat (4) queue_request(fill_base - 1, pick_digest());
    // oldest entry exactly at the window, then one second past it
    queue_request(fill_base + NOW_W'(WINDOW_MAX), fresh_digest());
    queue_request(fill_base + NOW_W'(WINDOW_MAX) + 1, fresh_digest());
    time_base = time_base + NOW_W'(64'h2_0000_0000);
    add_random_requests(40);

    wait_idle();
    write_window(WIN_W'($urandom_range(2, 5000)));
    add_random_requests(160);

    // Times over the whole 63-bit range, the maximum included. High stamps
    // stay in the future for later, lower times and crowd the table.
    wait_idle();
    write_window($urandom());
    queue_request(NOW_MAX, DIGEST_ONES);
    queue_request(NOW_MAX, DIGEST_ONES);
    queue_request(NOW_MAX - 1, DIGEST_ONES);
    queue_request(NOW_W'(1), '0);
    now_time = NOW_MAX;
    repeat (100) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0, 1, 2: now_time = NOW_W'({$urandom(), $urandom()});
        3, 4:    now_time = NOW_MAX - $urandom_range(0, 3);
        5:       now_time = now_time;
        default: now_time = NOW_W'({$urandom(), $urandom()}) >> $urandom_range(0, NOW_W - 1);
      endcase
      queue_request(now_time, pick_digest());
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (verdicts_due.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", verdicts_due.size()));
    end

    $display("ran %0d requests: %0d stored, %0d replays, %0d refused as full",
             accepted_total, seen_stored, seen_replay, seen_full);
    $display("windows 0, 1, 600, random and all ones; table filled; times up to 2^63-1");
    if (mismatch_count == 0) begin
      $display("nonce_replay_ledger_test: clean");
    end else begin
      $display("nonce_replay_ledger_test: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("run limit reached, %0d of %0d requests taken", accepted_total, queued_total);
    $display("nonce_replay_ledger_test: errors");
    $finish;
  end

endmodule

FILE: files.f
sv/nrl_pkg.sv
sv/nrl_req_if.sv
sv/nrl_rsp_if.sv
sv/nrl_front.sv
sv/nrl_queue.sv
sv/nrl_scan.sv
sv/nonce_replay_ledger.sv
sim/nonce_replay_ledger_test.sv
